/* rtl/polar_line_pair_intersection_macros.svh */
// Assertion macros shared by the polar line pair intersection RTL.
`ifndef POLAR_LINE_PAIR_INTERSECTION_MACROS_SVH
`define POLAR_LINE_PAIR_INTERSECTION_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define PLPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define PLPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/plpi_pkg.sv */
// Package with constants, types and the sine/cosine table builder.
package plpi_pkg;

    localparam int ANGLE_W      = 11;
    localparam int ANGLE_STEPS  = 2048;
    localparam int TURN_W       = 12;
    localparam int RADIUS_W     = 12;
    localparam int TRIG_W       = 32;
    localparam int PROD_W       = RADIUS_W + TRIG_W;
    localparam int NUM_W        = PROD_W + 1;
    localparam int DEN_W        = TRIG_W - 1;
    localparam int COORD_W      = 24;
    localparam int DIV_STAGES   = COORD_W + 1;
    localparam int ROM_DEPTH    = 513;
    localparam int ROM_AW       = 10;
    localparam int MIN_ANGLE_RESET = 64;

    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [2*DEN_W-1:0] sc_word_t;
    typedef sc_word_t sc_rom_t [ROM_DEPTH];

    typedef struct packed {
        logic accepted;
        logic zero_div;
    } plpi_tag_t;

    function automatic sc_rom_t sc_build();
        sc_rom_t tab;
        longint unsigned w;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned sv;
        longint unsigned cv;
        for (int m = 0; m < ROM_DEPTH; m++)
        begin
            w  = longint'(m) << 20;
            x  = (w * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t  = ONE_Q30 - (((x2 * ONE_Q30) >> 30) / 72);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 42);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 20);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 6);
            sv = (x * t) >> 30;
            t  = ONE_Q30 - (((x2 * ONE_Q30) >> 30) / 90);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 56);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 30);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 12);
            cv = ONE_Q30 - (((x2 * t) >> 30) / 2);
            tab[m] = {sv[DEN_W-1:0], cv[DEN_W-1:0]};
        end
        return tab;
    endfunction

endpackage

/* rtl/plpi_if.sv */
// Handshake interfaces for line pair items and intersection result items.
interface plpi_pair_if;
    import plpi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [RADIUS_W-1:0] first_radius;
    logic        [ANGLE_W-1:0]  first_angle;
    logic signed [RADIUS_W-1:0] second_radius;
    logic        [ANGLE_W-1:0]  second_angle;
    modport source (output valid, first_radius, first_angle, second_radius, second_angle,
                    input ready);
    modport sink (input valid, first_radius, first_angle, second_radius, second_angle,
                  output ready);
endinterface

interface plpi_result_if;
    import plpi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
    logic                      clipped;
    modport source (output valid, accepted, cross_x, cross_y, clipped, input ready);
    modport sink (input valid, accepted, cross_x, cross_y, clipped, output ready);
endinterface

/* rtl/plpi_sincos.sv */
// Two-stage sine and cosine lookup in Q30 for a 12-bit angle over a full turn.
module plpi_sincos
    import plpi_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [TURN_W-1:0]        angle,
    output logic signed [TRIG_W-1:0] sine,
    output logic signed [TRIG_W-1:0] cosine
);

    localparam sc_rom_t SC_ROM = sc_build();
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [TURN_W-3:0] frac;
    logic              swap;
    logic [ROM_AW-1:0] addr;
    sc_word_t          rd_reg;
    logic [1:0]        quad_reg;
    logic              swap_reg;
    logic signed [TRIG_W-1:0] sv;
    logic signed [TRIG_W-1:0] cv;
    logic signed [TRIG_W-1:0] sine_next;
    logic signed [TRIG_W-1:0] cosine_next;
    logic signed [TRIG_W-1:0] sine_reg;
    logic signed [TRIG_W-1:0] cosine_reg;

    assign frac = angle[TURN_W-3:0];
    assign swap = frac > (ROM_AW)'(ROM_DEPTH - 1);
    assign addr = swap ? (ROM_AW)'(2 * (ROM_DEPTH - 1) - int'(frac)) : frac;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg   <= SC_ROM[addr];
            quad_reg <= angle[TURN_W-1:TURN_W-2];
            swap_reg <= swap;
        end
    end

    always_comb
    begin
        if (swap_reg)
        begin
            sv = $signed({1'b0, rd_reg[DEN_W-1:0]});
            cv = $signed({1'b0, rd_reg[2*DEN_W-1:DEN_W]});
        end
        else
        begin
            sv = $signed({1'b0, rd_reg[2*DEN_W-1:DEN_W]});
            cv = $signed({1'b0, rd_reg[DEN_W-1:0]});
        end
        case (quad_reg)
            QUAD_0:
            begin
                sine_next   = sv;
                cosine_next = cv;
            end
            QUAD_1:
            begin
                sine_next   = cv;
                cosine_next = -sv;
            end
            QUAD_2:
            begin
                sine_next   = -sv;
                cosine_next = -cv;
            end
            default:
            begin
                sine_next   = -cv;
                cosine_next = sv;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule

/* rtl/plpi_div.sv */
// Pipelined restoring divider with rounding, saturation and sign for one coordinate.
module plpi_div
    import plpi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [NUM_W-1:0]   num_mag,
    input  logic [DEN_W-1:0]   den_mag,
    input  logic               neg,
    output logic               out_vld,
    output logic [COORD_W-1:0] coord,
    output logic               clip
);

    localparam int REM_W = NUM_W + 6;
    localparam int DD_W  = DEN_W + 1;
    localparam int CMP_W = DD_W + COORD_W;

    logic [REM_W-1:0]   num;
    logic [DD_W-1:0]    den;
    logic               ovf;
    logic [REM_W-1:0]   rem_reg [DIV_STAGES];
    logic [COORD_W-1:0] q_reg   [DIV_STAGES];
    logic [DD_W-1:0]    den_reg [DIV_STAGES];
    logic               neg_reg [DIV_STAGES];
    logic               ovf_reg [DIV_STAGES];
    logic               vld_reg [DIV_STAGES];
    logic [COORD_W-1:0] q;
    logic               big;

    assign num = (REM_W)'({num_mag, 5'b0}) + (REM_W)'(den_mag);
    assign den = {den_mag, 1'b0};
    assign ovf = (CMP_W)'(num) >= {den, {COORD_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf;
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++)
    begin : g_bit
        localparam int B = COORD_W - k;
        logic [CMP_W-1:0] shifted;
        logic             ge;

        assign shifted = (CMP_W)'(den_reg[k-1]) << B;
        assign ge      = (CMP_W)'(rem_reg[k-1]) >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? rem_reg[k-1] - shifted[REM_W-1:0] : rem_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (ge ? (COORD_W)'(1) << B : '0);
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign q   = q_reg[DIV_STAGES-1];
    assign big = neg_reg[DIV_STAGES-1] ? (q[COORD_W-1] && (|q[COORD_W-2:0])) : q[COORD_W-1];
    assign clip = ovf_reg[DIV_STAGES-1] || big;
    assign out_vld = vld_reg[DIV_STAGES-1];

    always_comb
    begin
        if (clip)
            coord = neg_reg[DIV_STAGES-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                          : {1'b0, {(COORD_W-1){1'b1}}};
        else
            coord = neg_reg[DIV_STAGES-1] ? -q : q;
    end

endmodule

/* rtl/polar_line_pair_intersection.sv */
// Top level: intersection of two polar lines with an angle separation test.
// One line pair is accepted every cycle unless the output is stalled, and each gives
// exactly one result item; the depth comes from the quotient pipeline of the two
// coordinate dividers, behind the table lookup and multiply stages. All stages
// advance together whenever the output register is empty or being taken.
`include "polar_line_pair_intersection_macros.svh"
module polar_line_pair_intersection
    import plpi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [ANGLE_W-1:0]  cfg_wr_data,
    plpi_pair_if.sink           pair,
    plpi_result_if.source       result
);

    logic                adv;
    logic [ANGLE_W-1:0]  min_angle_reg;
    logic [TURN_W-1:0]   w1;
    logic [TURN_W-1:0]   w2;
    logic [TURN_W-1:0]   adiff;
    logic                acc;
    logic [TURN_W-1:0]   dang;

    logic                vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic                acc1_reg, acc2_reg, acc3_reg;
    logic signed [RADIUS_W-1:0] r1_1_reg, r2_1_reg, r1_2_reg, r2_2_reg;

    logic signed [TRIG_W-1:0] s1, c1, s2, c2, sd;

    logic signed [PROD_W-1:0] p_r1s2_reg, p_r2s1_reg, p_r2c1_reg, p_r1c2_reg;
    logic signed [TRIG_W-1:0] sd3_reg;
    logic signed [NUM_W-1:0]  nx, ny;

    logic [NUM_W-1:0]    nx_mag_reg, ny_mag_reg;
    logic [DEN_W-1:0]    d_mag_reg;
    logic                negx_reg, negy_reg;
    plpi_tag_t           tag4_reg;
    plpi_tag_t           tag_reg [DIV_STAGES];

    logic                dvld;
    logic [COORD_W-1:0]  qx, qy;
    logic                clipx, clipy;

    logic                out_vld_reg;
    logic                out_acc_reg;
    logic [COORD_W-1:0]  out_x_reg;
    logic [COORD_W-1:0]  out_y_reg;
    logic                out_clip_reg;

    assign adv = !out_vld_reg || result.ready;
    assign pair.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_angle_reg <= (ANGLE_W)'(MIN_ANGLE_RESET);
        else if (cfg_wr_en)
            min_angle_reg <= cfg_wr_data;
    end

    assign w1 = {1'b0, pair.first_angle}
              + ((pair.first_angle < min_angle_reg) ? (TURN_W)'(ANGLE_STEPS) : '0);
    assign w2 = {1'b0, pair.second_angle}
              + ((pair.second_angle < min_angle_reg) ? (TURN_W)'(ANGLE_STEPS) : '0);
    assign adiff = (w1 > w2) ? w1 - w2 : w2 - w1;
    assign acc   = adiff > {1'b0, min_angle_reg};
    assign dang  = {1'b0, pair.second_angle} - {1'b0, pair.first_angle};

    plpi_sincos u_sc1 (
        .clk    (clk),
        .en     (adv),
        .angle  ({1'b0, pair.first_angle}),
        .sine   (s1),
        .cosine (c1)
    );

    plpi_sincos u_sc2 (
        .clk    (clk),
        .en     (adv),
        .angle  ({1'b0, pair.second_angle}),
        .sine   (s2),
        .cosine (c2)
    );

    plpi_sincos u_scd (
        .clk    (clk),
        .en     (adv),
        .angle  (dang),
        .sine   (sd),
        .cosine ()
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= pair.valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    assign nx = (NUM_W)'(p_r1s2_reg) - (NUM_W)'(p_r2s1_reg);
    assign ny = (NUM_W)'(p_r2c1_reg) - (NUM_W)'(p_r1c2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc1_reg   <= acc;
            r1_1_reg   <= pair.first_radius;
            r2_1_reg   <= pair.second_radius;
            acc2_reg   <= acc1_reg;
            r1_2_reg   <= r1_1_reg;
            r2_2_reg   <= r2_1_reg;
            acc3_reg   <= acc2_reg;
            p_r1s2_reg <= (PROD_W)'(r1_2_reg) * (PROD_W)'(s2);
            p_r2s1_reg <= (PROD_W)'(r2_2_reg) * (PROD_W)'(s1);
            p_r2c1_reg <= (PROD_W)'(r2_2_reg) * (PROD_W)'(c1);
            p_r1c2_reg <= (PROD_W)'(r1_2_reg) * (PROD_W)'(c2);
            sd3_reg    <= sd;
            nx_mag_reg <= nx[NUM_W-1] ? -nx : nx;
            ny_mag_reg <= ny[NUM_W-1] ? -ny : ny;
            d_mag_reg  <= sd3_reg[TRIG_W-1] ? DEN_W'(-sd3_reg) : DEN_W'(sd3_reg);
            negx_reg   <= nx[NUM_W-1] ^ sd3_reg[TRIG_W-1];
            negy_reg   <= ny[NUM_W-1] ^ sd3_reg[TRIG_W-1];
            tag4_reg.accepted <= acc3_reg;
            tag4_reg.zero_div <= (sd3_reg == '0);
        end
    end

    plpi_div u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (vld4_reg),
        .num_mag (nx_mag_reg),
        .den_mag (d_mag_reg),
        .neg     (negx_reg),
        .out_vld (dvld),
        .coord   (qx),
        .clip    (clipx)
    );

    plpi_div u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (vld4_reg),
        .num_mag (ny_mag_reg),
        .den_mag (d_mag_reg),
        .neg     (negy_reg),
        .out_vld (),
        .coord   (qy),
        .clip    (clipy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
            tag_reg[0] <= tag4_reg;
    end

    for (genvar k = 1; k < DIV_STAGES; k++)
    begin : g_tag
        always_ff @(posedge clk)
        begin
            if (adv)
                tag_reg[k] <= tag_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= dvld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_acc_reg <= tag_reg[DIV_STAGES-1].accepted;
            if (!tag_reg[DIV_STAGES-1].accepted)
            begin
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_clip_reg <= 1'b0;
            end
            else if (tag_reg[DIV_STAGES-1].zero_div)
            begin
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_clip_reg <= 1'b1;
            end
            else
            begin
                out_x_reg    <= qx;
                out_y_reg    <= qy;
                out_clip_reg <= clipx || clipy;
            end
        end
    end

    assign result.valid    = out_vld_reg;
    assign result.accepted = out_acc_reg;
    assign result.cross_x  = out_x_reg;
    assign result.cross_y  = out_y_reg;
    assign result.clipped  = out_clip_reg;

    `PLPI_ASSERT_NOW(a_reject_zero, result.valid && !result.accepted,
        result.cross_x == '0 && result.cross_y == '0 && !result.clipped,
        "Rejected pair carries nonzero coordinates or clip.")
    `PLPI_ASSERT_NOW(a_clip_needs_accept, result.valid && result.clipped,
        result.accepted, "Clip flag set on a rejected pair.")
    `PLPI_ASSERT_NEXT(a_stage_moves, adv && vld1_reg, vld2_reg,
        "Item lost between lookup stages.")

endmodule
